FILE: design/ddo_pkg.sv
package ddo_pkg;

  localparam int ANGLE_BITS_DEF   = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int SEP_W  = 20;
  localparam int INV_W  = 24;
  localparam int VEL_W  = 24;
  localparam int DT_W   = 17;
  localparam int POS_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SEPARATION     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_WHEEL_RADIUS = 2'd1;

  localparam logic [SEP_W-1:0] SEP_RESET = 20'd19661;
  localparam logic [INV_W-1:0] INV_RESET = 24'd1310720;

  // 2^32 / (2 pi), rounded
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  // CORDIC start value, 0.60725293500888 in Q1.30
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  // multiplier operation sequence
  localparam logic [3:0] OP_OFFSET   = 4'd0;
  localparam logic [3:0] OP_LRATE    = 4'd1;
  localparam logic [3:0] OP_LRATE_DT = 4'd2;
  localparam logic [3:0] OP_LTURNS   = 4'd3;
  localparam logic [3:0] OP_RRATE    = 4'd4;
  localparam logic [3:0] OP_RRATE_DT = 4'd5;
  localparam logic [3:0] OP_RTURNS   = 4'd6;
  localparam logic [3:0] OP_DIST     = 4'd7;
  localparam logic [3:0] OP_DX       = 4'd8;
  localparam logic [3:0] OP_DY       = 4'd9;
  localparam logic [3:0] OP_W_DT     = 4'd10;
  localparam logic [3:0] OP_HTURNS   = 4'd11;

  typedef struct packed {
    logic       start;
    logic       b_signed;
    logic [5:0] nbits;
  } mul_req_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: design/ddo_in_if.sv
interface ddo_in_if import ddo_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] linear_velocity;
  logic signed [VEL_W-1:0] angular_velocity;
  logic [DT_W-1:0]         elapsed_time;

  modport source (output valid, linear_velocity, angular_velocity, elapsed_time,
                  input ready);
  modport sink (input valid, linear_velocity, angular_velocity, elapsed_time,
                output ready);
endinterface

FILE: design/ddo_out_if.sv
interface ddo_out_if import ddo_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [ANGLE_BITS-1:0]   left_wheel_angle;
  logic [ANGLE_BITS-1:0]   right_wheel_angle;
  logic signed [POS_W-1:0] position_x;
  logic signed [POS_W-1:0] position_y;
  logic [ANGLE_BITS-1:0]   heading;
  logic                    position_saturated;

  modport source (output valid, left_wheel_angle, right_wheel_angle, position_x,
                  position_y, heading, position_saturated, input ready);
  modport sink (input valid, left_wheel_angle, right_wheel_angle, position_x,
                position_y, heading, position_saturated, output ready);
endinterface

FILE: design/ddo_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, product mod 2^64.
module ddo_mul import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);
  logic        busy;
  logic [5:0]  cnt;
  logic [5:0]  nbits;
  logic        b_signed;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic        last;

  assign last = (cnt == nbits - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod     <= '0;
      mcand    <= a;
      mplier   <= b;
      nbits    <= req.nbits;
      b_signed <= req.b_signed;
    end else if (busy) begin
      // top bit of a signed multiplier weighs negative
      if (mplier[0]) begin
        if (b_signed && last) prod <= prod - mcand;
        else                  prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end
endmodule

FILE: design/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module ddo_cordic import ddo_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [31:0]    cos_q30,
  output logic signed [31:0]    sin_q30
);
  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic signed [32:0]  x, y, z;
  logic                neg;
  logic [31:0]         a32;
  logic [31:0]         a_fold;
  logic [31:0]         atan_v;
  logic signed [32:0]  xs, ys;

  assign a32    = 32'(angle) << (32 - ANGLE_BITS);
  // second and third quadrant: rotate by a half turn, negate at the end
  assign a_fold = {a32[31] ^ (a32[31] ^ a32[30]), a32[30:0]};
  assign atan_v = atan_lut(5'(cnt));
  assign xs     = x >>> cnt;
  assign ys     = y >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(CORDIC_STEPS - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= CORDIC_START;
      y   <= '0;
      z   <= 33'($signed(a_fold));
      neg <= a32[31] ^ a32[30];
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - $signed({1'b0, atan_v});
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + $signed({1'b0, atan_v});
      end
    end
  end

  assign cos_q30 = neg ? 32'(-x) : 32'(x);
  assign sin_q30 = neg ? 32'(-y) : 32'(y);
endmodule

FILE: design/diff_drive_odometry_unit.sv
// Differential-drive odometry by dead reckoning. Each accepted tick item
// (linear and angular velocity in Q8.16, elapsed time in 2^-16 s) yields one
// result item: both wheel angles and the heading as wrapping binary angles,
// and x/y in Q16.16 that saturate at the 32-bit limits (position_saturated
// flags a clamp on this tick). The pose update uses the heading from before
// the tick. All arithmetic runs through one bit-serial shift-add multiplier,
// twelve products per item, one after another. When the output register is
// free, the result valid rises and the input is ready again in that same
// cycle; the block takes no new item before the last one's result is in the
// output register. The CORDIC for the old heading runs alongside the first
// products and never adds latency.
// A new item is taken as soon as the previous result sits in the output
// register, even if that result has not yet been taken. Configuration writes
// (index 0 wheel separation, index 1 inverse wheel radius; other indexes are
// dropped) must only happen while the block is idle.
module diff_drive_odometry_unit import ddo_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ddo_in_if.sink                in_ch,
  ddo_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

  logic [1:0] state;
  logic [3:0] op;

  // configuration
  logic [SEP_W-1:0] sep;
  logic [INV_W-1:0] inv_r;

  // odometry state
  logic [ANGLE_BITS-1:0]   left_acc, right_acc, head;
  logic signed [POS_W-1:0] pose_x, pose_y;
  logic                    sat_hit;

  // captured item and intermediates
  logic signed [VEL_W-1:0] v, w;
  logic [DT_W-1:0]         dt;
  logic signed [26:0]      offset;
  logic signed [35:0]      rate;
  logic signed [52:0]      tmp;
  logic signed [24:0]      travel;

  // multiplier and CORDIC hookup
  mul_req_t           mreq;
  logic [63:0]        ma;
  logic [31:0]        mb;
  logic               mdone;
  logic [63:0]        mprod;
  logic signed [31:0] cos_v, sin_v;
  logic               accept;

  logic signed [33:0] pos_sum;
  logic signed [POS_W-1:0] pos_clamped;
  logic               pos_clip;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  ddo_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .a   (ma),
    .b   (mb),
    .done(mdone),
    .prod(mprod)
  );

  ddo_cordic #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .angle  (head),
    .cos_q30(cos_v),
    .sin_q30(sin_v)
  );

  // operand selection for each step of the sequence
  always_comb begin
    mreq.start    = (state == S_ISSUE);
    mreq.b_signed = 1'b0;
    mreq.nbits    = 6'd17;
    ma            = 64'(v);
    mb            = 32'(dt);
    case (op)
      OP_OFFSET: begin
        ma = 64'(w);
        mb = 32'(sep);
        mreq.nbits = 6'(SEP_W);
      end
      OP_LRATE: begin
        ma = 64'(28'(v) - 28'(offset));
        mb = 32'(inv_r);
        mreq.nbits = 6'(INV_W);
      end
      OP_RRATE: begin
        ma = 64'(28'(v) + 28'(offset));
        mb = 32'(inv_r);
        mreq.nbits = 6'(INV_W);
      end
      OP_LRATE_DT, OP_RRATE_DT: begin
        ma = 64'(rate);
      end
      OP_LTURNS, OP_RTURNS, OP_HTURNS: begin
        ma = 64'(tmp);
        mb = 32'(INV_TWO_PI_Q32);
        mreq.nbits = 6'd30;
      end
      OP_DIST: begin
        ma = 64'(v);
      end
      OP_DX, OP_DY: begin
        ma = 64'(travel);
        mb = (op == OP_DX) ? cos_v : sin_v;
        mreq.b_signed = 1'b1;
        mreq.nbits = 6'd32;
      end
      OP_W_DT: begin
        ma = 64'(w);
      end
      default: begin
        ma = 64'(v);
      end
    endcase
  end

  // saturating position update, dx/dy = product >> 30
  always_comb begin
    if (op == OP_DX) pos_sum = 34'(pose_x) + 34'($signed(mprod[56:30]));
    else             pos_sum = 34'(pose_y) + 34'($signed(mprod[56:30]));
    pos_clip    = 1'b0;
    pos_clamped = 32'(pos_sum);
    if (pos_sum > POS_MAX) begin
      pos_clip    = 1'b1;
      pos_clamped = 32'(POS_MAX);
    end else if (pos_sum < POS_MIN) begin
      pos_clip    = 1'b1;
      pos_clamped = 32'(POS_MIN);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= '0;
      out_ch.valid <= 1'b0;
      sep          <= SEP_RESET;
      inv_r        <= INV_RESET;
      left_acc     <= '0;
      right_acc    <= '0;
      head         <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WHEEL_SEPARATION:     sep   <= cfg_data[SEP_W-1:0];
          REG_INVERSE_WHEEL_RADIUS: inv_r <= cfg_data[INV_W-1:0];
          default: ;
        endcase
      end
      // a new result may replace one taken on this same edge
      if (state == S_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= OP_OFFSET;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mdone) begin
            case (op)
              OP_LTURNS: left_acc  <= left_acc + mprod[63 -: ANGLE_BITS];
              OP_RTURNS: right_acc <= right_acc + mprod[63 -: ANGLE_BITS];
              OP_HTURNS: head      <= head + mprod[63 -: ANGLE_BITS];
              OP_DX:     pose_x    <= pos_clamped;
              OP_DY:     pose_y    <= pos_clamped;
              default: ;
            endcase
            if (op == OP_HTURNS) begin
              state <= S_OUT;
            end else begin
              op    <= op + 4'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_ch.valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      v       <= in_ch.linear_velocity;
      w       <= in_ch.angular_velocity;
      dt      <= in_ch.elapsed_time;
      sat_hit <= 1'b0;
    end
    if (state == S_WAIT && mdone) begin
      case (op)
        OP_OFFSET:                         offset <= $signed(mprod[43:17]);
        OP_LRATE, OP_RRATE:                rate   <= $signed(mprod[51:16]);
        OP_LRATE_DT, OP_RRATE_DT, OP_W_DT: tmp    <= $signed(mprod[52:0]);
        OP_DIST:                           travel <= $signed(mprod[40:16]);
        OP_DX, OP_DY:                      sat_hit <= sat_hit | pos_clip;
        default: ;
      endcase
    end
    if (state == S_OUT && (!out_ch.valid || out_ch.ready)) begin
      out_ch.left_wheel_angle   <= left_acc;
      out_ch.right_wheel_angle  <= right_acc;
      out_ch.position_x         <= pose_x;
      out_ch.position_y         <= pose_y;
      out_ch.heading            <= head;
      out_ch.position_saturated <= sat_hit;
    end
  end
endmodule

FILE: design/ddo_checker.sv
module ddo_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [151:0] out_payload
);
  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a new result appears together with the block going idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while block still busy");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");
endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_payload(152'({out_ch.left_wheel_angle, out_ch.right_wheel_angle,
                     out_ch.position_x, out_ch.position_y, out_ch.heading,
                     out_ch.position_saturated}))
);

FILE: tb/sv/diff_drive_odometry_unit_tb.sv
module diff_drive_odometry_unit_tb;
  import ddo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one tick item as the sender offers it
  typedef struct {
    logic signed [VEL_W-1:0] lin;
    logic signed [VEL_W-1:0] ang;
    logic [DT_W-1:0]         dt;
  } tick_t;

  // one odometry result item
  typedef struct {
    logic [ANGLE_BITS_DEF-1:0] left_ang;
    logic [ANGLE_BITS_DEF-1:0] right_ang;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [ANGLE_BITS_DEF-1:0] head;
    logic                      sat;
  } pose_t;

  localparam int   HOLD_CYCLES  = 1500;
  localparam int   DRAIN_CYCLES = 400;   // longer than one item's full pass through the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh800000;
  localparam logic [DT_W-1:0] DT_MAX = 17'h1FFFF;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ddo_in_if  in_ch();
  ddo_out_if out_ch();

  diff_drive_odometry_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Odometry predictor: own copy of registers and pose state
  // ---------------------------------------------------------------------------
  logic [SEP_W-1:0] m_sep;
  logic [INV_W-1:0] m_inv;
  logic [ANGLE_BITS_DEF-1:0] m_left, m_right, m_head;
  longint m_x, m_y;

  // arctangent table, 2^32 per turn
  bit [31:0] atan_q32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  // radians in Q.32 to binary angle step; product wraps at 64 bits
  function automatic logic [ANGLE_BITS_DEF-1:0] rad_to_bam(longint rad);
    bit [63:0] t;
    t = 64'(rad) * 64'(INV_TWO_PI_Q32);
    return t[63 -: ANGLE_BITS_DEF];
  endfunction

  // cos/sin of a binary angle in Q1.30
  function automatic void heading_cos_sin(input logic [ANGLE_BITS_DEF-1:0] h,
                                          output longint c, output longint s);
    bit [31:0] a;
    bit        neg;
    longint    x, y, z, nx;
    a = 32'(h) << (32 - ANGLE_BITS_DEF);
    neg = 1'b0;
    // fold the left half-plane onto the right one
    if (a >= 32'h40000000 && a < 32'hC0000000) begin
      a = a - 32'h80000000;
      neg = 1'b1;
    end
    x = CORDIC_START;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(atan_q32[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(atan_q32[i]);
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint clamp_add(longint a, longint d, inout bit hit);
    longint r;
    r = a + d;
    if (r > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (r < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return r;
  endfunction

  // advance the predicted state by one tick and return the expected result
  function automatic pose_t odometry_step(tick_t t);
    longint v, w, dt, offs, lrate, rrate, travel, c, s;
    bit     hit;
    pose_t  r;
    v  = longint'(t.lin);
    w  = longint'(t.ang);
    dt = longint'({1'b0, t.dt});
    offs  = (w * longint'({1'b0, m_sep})) >>> 17;
    lrate = ((v - offs) * longint'({1'b0, m_inv})) >>> 16;
    rrate = ((v + offs) * longint'({1'b0, m_inv})) >>> 16;
    travel = (v * dt) >>> 16;
    hit = 1'b0;
    m_left  = m_left + rad_to_bam(lrate * dt);
    m_right = m_right + rad_to_bam(rrate * dt);
    // pose uses the heading from before this tick
    heading_cos_sin(m_head, c, s);
    m_x = clamp_add(m_x, (travel * c) >>> 30, hit);
    m_y = clamp_add(m_y, (travel * s) >>> 30, hit);
    m_head = m_head + rad_to_bam(w * dt);
    r.left_ang  = m_left;
    r.right_ang = m_right;
    r.pos_x     = m_x[31:0];
    r.pos_y     = m_y[31:0];
    r.head      = m_head;
    r.sat       = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, flags, counters
  // ---------------------------------------------------------------------------
  tick_t pending_ticks[$];
  pose_t expected_poses[$];
  bit    quiet;       // no idling on either side
  bit    send_hold;   // sender pauses, no new items
  bit    hold_req;
  bit    hold_out;    // long receiver hold-off
  bit    failed;
  logic  in_fire;
  int    send_gap;
  int    stall_cnt;

  // ---------------------------------------------------------------------------
  // Driver: items go out at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    tick_t t;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ticks.size() > 0 && !send_hold && !quiet &&
                   $urandom_range(0, 5) == 0) begin
        // idle burst; this cycle counts as its first
        send_gap = $urandom_range(1, 17) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ticks.size() > 0 && !send_hold) begin
        t = pending_ticks.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.linear_velocity  <= t.lin;
        in_ch.angular_velocity <= t.ang;
        in_ch.elapsed_time     <= t.dt;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus the long hold-off
  always @(negedge clk) begin
    if (stall_cnt > 0)
      stall_cnt = stall_cnt - 1;
    else if (!quiet && $urandom_range(0, 4) == 0)
      stall_cnt = $urandom_range(1, 17);
    out_ch.ready <= (stall_cnt == 0) && !hold_out && !rst;
  end

  // long hold-off, counted here so the sender keeps offering items
  initial begin
    hold_out = 1'b0;
    wait (hold_req);
    @(negedge clk);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_out = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted ticks, check accepted results
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    tick_t t;
    pose_t e;
    in_fire = !rst && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      t.lin = in_ch.linear_velocity;
      t.ang = in_ch.angular_velocity;
      t.dt  = in_ch.elapsed_time;
      expected_poses.push_back(odometry_step(t));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_poses.size() == 0) begin
        $error("result item with no expected pose");
        failed = 1'b1;
      end else begin
        e = expected_poses.pop_front();
        check_field("left_wheel_angle", e.left_ang, out_ch.left_wheel_angle);
        check_field("right_wheel_angle", e.right_ang, out_ch.right_wheel_angle);
        check_field("position_x", e.pos_x, out_ch.position_x);
        check_field("position_y", e.pos_y, out_ch.position_y);
        check_field("heading", e.head, out_ch.heading);
        check_field("position_saturated", e.sat, out_ch.position_saturated);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_tick(logic signed [VEL_W-1:0] v, logic signed [VEL_W-1:0] w,
                          logic [DT_W-1:0] dt);
    tick_t t;
    t.lin = v;
    t.ang = w;
    t.dt  = dt;
    pending_ticks.push_back(t);
  endtask

  // mix of full-range, realistic and extreme ticks
  task automatic add_random_ticks(int n);
    logic signed [VEL_W-1:0] v, w;
    logic [DT_W-1:0]         dt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          v  = VEL_W'($urandom);
          w  = VEL_W'($urandom);
          dt = DT_W'($urandom);
        end
        1: begin
          // plausible robot speeds at a 10 Hz tick
          v  = VEL_W'(int'($urandom_range(0, 2 ** 19)) - 2 ** 18);
          w  = VEL_W'(int'($urandom_range(0, 2 ** 19)) - 2 ** 18);
          dt = DT_W'($urandom_range(0, 13107));
        end
        2: begin
          v  = ($urandom_range(0, 1) != 0) ? VEL_MAX : VEL_MIN;
          w  = ($urandom_range(0, 1) != 0) ? VEL_MAX : VEL_MIN;
          dt = ($urandom_range(0, 1) != 0) ? DT_MAX : DT_W'($urandom_range(0, 3));
        end
        default: begin
          v  = VEL_W'($urandom);
          w  = VEL_W'(int'($urandom_range(0, 7)) - 4);
          dt = ($urandom_range(0, 3) == 0) ? 17'd0 : DT_W'($urandom);
        end
      endcase
      add_tick(v, w, dt);
    end
  endtask

  // long straight run at near top speed to drive x/y into the clamp
  task automatic add_dash(int n, bit reverse);
    logic signed [VEL_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      v = reverse ? VEL_MIN + VEL_W'($urandom_range(0, 255))
                  : VEL_MAX - VEL_W'($urandom_range(0, 255));
      add_tick(v, 24'sd0, DT_MAX - DT_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_WHEEL_SEPARATION)
      m_sep = data[SEP_W-1:0];
    else if (idx == REG_INVERSE_WHEEL_RADIUS)
      m_inv = data[INV_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued tick is taken and every result checked
  task automatic wait_idle();
    while (pending_ticks.size() > 0 || expected_poses.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_WHEEL_SEPARATION;
    cfg_data  = '0;
    in_ch.valid            = 1'b0;
    in_ch.linear_velocity  = '0;
    in_ch.angular_velocity = '0;
    in_ch.elapsed_time     = '0;
    out_ch.ready = 1'b0;
    quiet = 1'b0;
    send_hold = 1'b0;
    hold_req = 1'b0;
    failed = 1'b0;
    in_fire = 1'b0;
    send_gap = 0;
    stall_cnt = 0;
    m_sep = SEP_RESET;
    m_inv = INV_RESET;
    m_left = '0;
    m_right = '0;
    m_head = '0;
    m_x = 0;
    m_y = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero dt, field extremes, heading wrap, reset registers
    add_tick(24'sd0, 24'sd0, 17'd0);
    add_tick(VEL_MAX, VEL_MAX, 17'd0);       // zero time: nothing moves
    add_tick(24'sd65536, 24'sd0, 17'd6554);
    add_tick(VEL_MAX, 24'sd0, DT_MAX);
    add_tick(VEL_MIN, 24'sd0, DT_MAX);
    add_tick(24'sd0, VEL_MAX, DT_MAX);       // heading wraps several turns
    add_tick(24'sd0, VEL_MIN, DT_MAX);
    add_tick(VEL_MAX, VEL_MIN, 17'd1);
    add_tick(VEL_MIN, VEL_MAX, 17'd1);
    add_tick(24'sd1, 24'sd1, 17'd1);
    add_tick(-24'sd1, -24'sd1, DT_MAX);
    add_tick(24'sd65536, 24'sd102944, 17'd65536);  // ~quarter turn
    add_tick(24'sd65536, 24'sd0, 17'd65536);
    add_tick(24'sd65536, 24'sd102944, 17'd65536);
    add_tick(24'sd65536, 24'sd0, 17'd65536);
    add_tick(VEL_MAX, VEL_MAX, DT_MAX);
    add_tick(VEL_MIN, VEL_MIN, DT_MAX);
    add_tick(24'sh555555, 24'shAAAAAA, 17'h15555);
    add_tick(24'shAAAAAA, 24'sh555555, 17'h0AAAA);
    add_random_ticks(40);
    wait_idle();

    // register extremes; unused indexes must be dropped
    write_reg(REG_WHEEL_SEPARATION, {CFG_DATA_W{1'b1}});
    write_reg(REG_INVERSE_WHEEL_RADIUS, {CFG_DATA_W{1'b1}});
    write_reg(REG_UNUSED_2, CFG_DATA_W'($urandom));
    write_reg(REG_UNUSED_3, CFG_DATA_W'($urandom));
    add_random_ticks(150);
    // sender pause mid-phase until every result is back
    wait_idle();
    add_random_ticks(50);
    wait_idle();

    write_reg(REG_WHEEL_SEPARATION, '0);
    write_reg(REG_INVERSE_WHEEL_RADIUS, '0);
    add_random_ticks(100);
    wait_idle();

    // random registers; straight dashes push x/y into both clamps
    write_reg(REG_WHEEL_SEPARATION, CFG_DATA_W'($urandom));
    write_reg(REG_INVERSE_WHEEL_RADIUS, CFG_DATA_W'($urandom));
    add_dash(200, 1'b0);
    add_dash(200, 1'b1);
    add_random_ticks(60);
    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    wait_idle();

    write_reg(REG_WHEEL_SEPARATION, CFG_DATA_W'(SEP_RESET));
    write_reg(REG_INVERSE_WHEEL_RADIUS, INV_RESET);
    add_random_ticks(100);
    wait_idle();
    // last stretch runs with no idling
    quiet = 1'b1;
    add_random_ticks(150);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_poses.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // run-time guard, several times the slowest correct run
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
